>>> design/chme_pkg.sv
`default_nettype none
package chme_pkg;

  // Table capacity. The bucket is taken from the low hash bits, so this must be a power of two.
  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  // Operation codes.
  localparam logic [2:0] OP_GET        = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_SET        = 3'd2;
  localparam logic [2:0] OP_SET_INSERT = 3'd3;
  localparam logic [2:0] OP_ERASE      = 3'd4;
  localparam logic [2:0] OP_READ_INDEX = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [31:0] key_hash;
    logic [63:0] value;
    logic [9:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] key_out;
    logic [63:0] value_out;
    logic [10:0] entry_count;
  } rsp_t;

endpackage
`default_nettype wire

>>> design/chained_hash_map_engine.sv
`default_nettype none
// Lookups read the bucket head, then probe the chain one entry at a time; insert appends a slot,
// erase unlinks the entry and moves the last slot into its hole, read by index reads one slot
// and clear sweeps the head memory. Unused op codes answer OK. A stalled result delays the next.
// One request is in flight at a time; each memory gives one write and one read per cycle.
// Reset is synchronous: the block sweeps every head memory entry to empty, with req_stall high.
// The result register lets a new request enter while the previous result still waits.
module chained_hash_map_engine
  import chme_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HEAD  = 4'd1;
  localparam logic [3:0] S_HEADW = 4'd2;
  localparam logic [3:0] S_PROBE = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_ADD2  = 4'd6;
  localparam logic [3:0] S_RM1   = 4'd7;
  localparam logic [3:0] S_RM2   = 4'd8;
  localparam logic [3:0] S_RM3   = 4'd9;
  localparam logic [3:0] S_RM4   = 4'd10;
  localparam logic [3:0] S_RIDX  = 4'd11;
  localparam logic [3:0] S_RIDXW = 4'd12;
  localparam logic [3:0] S_CLR   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam logic [CNT_W-1:0] NIL = CNT_W'(ENTRIES);

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] clr_ptr;
  logic             clr_reply;
  logic [2:0]       r_op;
  logic [63:0]      r_key;
  logic [63:0]      r_value;
  logic [IDX_W-1:0] r_bucket;
  logic [9:0]       r_sidx;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] head_q;
  logic [CNT_W-1:0] p_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] lp_q;
  logic [CNT_W-1:0] ln_q;
  logic [IDX_W-1:0] lb_q;
  logic [2:0]       st;
  logic [63:0]      ko;
  logic [63:0]      vo;

  // Memories.
  logic [CNT_W-1:0] heads_mem [ENTRIES];
  logic [63:0]      key_mem   [ENTRIES];
  logic [63:0]      val_mem   [ENTRIES];
  logic [CNT_W-1:0] next_mem  [ENTRIES];
  logic [CNT_W-1:0] prev_mem  [ENTRIES];
  logic [IDX_W-1:0] bkt_mem   [ENTRIES];

  logic [CNT_W-1:0] head_rd, next_rd, prev_rd;
  logic [63:0]      key_rd, val_rd;
  logic [IDX_W-1:0] bkt_rd;
  logic [IDX_W-1:0] slot_raddr;

  logic             hw_en;
  logic [IDX_W-1:0] hw_addr;
  logic [CNT_W-1:0] hw_data;
  logic             kw_en, vw_en, bw_en, nw_en, pw_en;
  logic [IDX_W-1:0] kv_addr, nw_addr, pw_addr;
  logic [63:0]      kw_data, vw_data;
  logic [IDX_W-1:0] bw_data;
  logic [CNT_W-1:0] nw_data, pw_data;

  logic [CNT_W-1:0] last;
  logic             key_hit;
  logic             req_acc;

  assign last      = count - CNT_W'(1);
  assign key_hit   = (key_rd == r_key);
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;

  // Address and write-port selection per sequencer step.
  always_comb begin
    slot_raddr = cur[IDX_W-1:0];
    hw_en = 1'b0; hw_addr = r_bucket; hw_data = NIL;
    kw_en = 1'b0; vw_en = 1'b0; bw_en = 1'b0; nw_en = 1'b0; pw_en = 1'b0;
    kv_addr = cur[IDX_W-1:0]; kw_data = r_key; vw_data = r_value; bw_data = r_bucket;
    nw_addr = cur[IDX_W-1:0]; nw_data = NIL;
    pw_addr = cur[IDX_W-1:0]; pw_data = NIL;
    unique case (state)
      S_RIDX: slot_raddr = IDX_W'(r_sidx);
      S_RM2:  slot_raddr = last[IDX_W-1:0];
      S_CMP: begin
        if (key_hit && (r_op == OP_SET || r_op == OP_SET_INSERT)) begin
          vw_en = 1'b1;
        end
      end
      S_ADD: begin
        kv_addr = count[IDX_W-1:0];
        kw_en = 1'b1; vw_en = 1'b1; bw_en = 1'b1;
        nw_en = 1'b1; nw_addr = count[IDX_W-1:0]; nw_data = head_q;
        pw_en = 1'b1; pw_addr = count[IDX_W-1:0]; pw_data = NIL;
        hw_en = 1'b1; hw_data = count;
      end
      S_ADD2: begin
        pw_en = 1'b1; pw_addr = head_q[IDX_W-1:0]; pw_data = count;
      end
      S_RM1: begin
        if (!p_q[IDX_W]) begin
          nw_en = 1'b1; nw_addr = p_q[IDX_W-1:0]; nw_data = n_q;
        end else begin
          hw_en = 1'b1; hw_data = n_q;
        end
        if (!n_q[IDX_W]) begin
          pw_en = 1'b1; pw_addr = n_q[IDX_W-1:0]; pw_data = p_q;
        end
      end
      S_RM3: begin
        kw_en = 1'b1; vw_en = 1'b1; bw_en = 1'b1;
        kw_data = key_rd; vw_data = val_rd; bw_data = bkt_rd;
        nw_en = 1'b1; nw_data = next_rd;
        pw_en = 1'b1; pw_data = prev_rd;
      end
      S_RM4: begin
        if (!lp_q[IDX_W]) begin
          nw_en = 1'b1; nw_addr = lp_q[IDX_W-1:0]; nw_data = cur;
        end else begin
          hw_en = 1'b1; hw_addr = lb_q; hw_data = cur;
        end
        if (!ln_q[IDX_W]) begin
          pw_en = 1'b1; pw_addr = ln_q[IDX_W-1:0]; pw_data = cur;
        end
      end
      S_CLR: begin
        hw_en = 1'b1; hw_addr = clr_ptr; hw_data = NIL;
      end
      default: ;
    endcase
  end

  // Head memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (hw_en) heads_mem[hw_addr] <= hw_data;
    head_rd <= heads_mem[r_bucket];
  end

  // Slot memories, all read at the same slot.
  always_ff @(posedge clk) begin
    if (kw_en) key_mem[kv_addr] <= kw_data;
    if (vw_en) val_mem[kv_addr] <= vw_data;
    if (bw_en) bkt_mem[kv_addr] <= bw_data;
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    key_rd  <= key_mem[slot_raddr];
    val_rd  <= val_mem[slot_raddr];
    bkt_rd  <= bkt_mem[slot_raddr];
    next_rd <= next_mem[slot_raddr];
    prev_rd <= prev_mem[slot_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_ptr   <= '0;
      clr_reply <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A result taken while no new one is ready leaves the output empty.
      if (rsp_valid && !rsp_stall && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            r_op     <= req.op;
            r_key    <= req.key;
            r_value  <= req.value;
            r_bucket <= req.key_hash[IDX_W-1:0];
            r_sidx   <= req.slot_index;
            st <= ST_OK; ko <= '0; vo <= '0;
            case (req.op) inside
              OP_GET, OP_INSERT, OP_SET, OP_SET_INSERT, OP_ERASE: state <= S_HEAD;
              OP_READ_INDEX: state <= S_RIDX;
              OP_CLEAR: begin
                state     <= S_CLR;
                clr_ptr   <= '0;
                clr_reply <= 1'b1;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_HEAD: state <= S_HEADW;
        S_HEADW: begin
          cur    <= head_rd;
          head_q <= head_rd;
          state  <= S_PROBE;
        end
        S_PROBE: begin
          if (cur >= count) begin
            if (r_op == OP_INSERT || r_op == OP_SET_INSERT) begin
              if (count[IDX_W]) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else begin
                state <= S_ADD;
              end
            end else begin
              st    <= ST_NOT_FOUND;
              state <= S_DONE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_hit) begin
            state <= S_DONE;
            case (r_op)
              OP_GET:    vo <= val_rd;
              OP_INSERT: st <= ST_PRESENT;
              OP_ERASE: begin
                p_q   <= prev_rd;
                n_q   <= next_rd;
                state <= S_RM1;
              end
              default: ;
            endcase
          end else begin
            cur   <= next_rd;
            state <= S_PROBE;
          end
        end
        S_ADD: begin
          if (!head_q[IDX_W]) begin
            state <= S_ADD2;
          end else begin
            count <= count + CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_ADD2: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_RM1: begin
          if (cur != last) begin
            state <= S_RM2;
          end else begin
            count <= last;
            state <= S_DONE;
          end
        end
        S_RM2: state <= S_RM3;
        S_RM3: begin
          lp_q  <= prev_rd;
          ln_q  <= next_rd;
          lb_q  <= bkt_rd;
          state <= S_RM4;
        end
        S_RM4: begin
          count <= last;
          state <= S_DONE;
        end
        S_RIDX: begin
          if (32'(r_sidx) >= 32'(count)) begin
            st    <= ST_RANGE;
            state <= S_DONE;
          end else begin
            state <= S_RIDXW;
          end
        end
        S_RIDXW: begin
          ko    <= key_rd;
          vo    <= val_rd;
          state <= S_DONE;
        end
        S_CLR: begin
          clr_ptr <= clr_ptr + IDX_W'(1);
          if (clr_ptr == IDX_W'(ENTRIES - 1)) begin
            count <= '0;
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.status      <= st;
      rsp.key_out     <= ko;
      rsp.value_out   <= vo;
      rsp.entry_count <= 11'(count);
    end
  end

  // The entry count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= NIL)
    else $error("entry count above capacity");

  // An append happens only when a free slot exists.
  a_add_room: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |-> !count[IDX_W])
    else $error("append into a full table");

  // Erase only runs with at least one stored entry.
  a_rm_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_RM1 |-> (count != '0 && cur < count))
    else $error("erase of a slot beyond the count");

  // An accepted request leaves the idle state on the next cycle.
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> state != S_IDLE)
    else $error("request accepted without leaving idle");

endmodule
`default_nettype wire

>>> bench/testbench.sv
module testbench;
  import chme_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  chained_hash_map_engine u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  localparam int NIL = ENTRIES;

  // Shadow copy of the table state.
  logic [63:0] sh_key [ENTRIES];
  logic [63:0] sh_val [ENTRIES];
  int          sh_next [ENTRIES];
  int          sh_prev [ENTRIES];
  int          sh_bkt [ENTRIES];
  int          sh_head [ENTRIES];
  int          sh_count;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   fail_count = 0;
  int   send_idle_pct = 17;
  int   recv_idle_pct = 85;
  bit   hold_sender = 1'b0;

  // Walk a chain looking for a key; returns NIL when absent.
  function automatic int find_slot(logic [63:0] k, int b);
    int i;
    int steps;
    i = sh_head[b];
    steps = 0;
    while (i < sh_count && i < ENTRIES && steps < ENTRIES) begin
      if (sh_key[i] == k) return i;
      i = sh_next[i];
      steps++;
    end
    return NIL;
  endfunction

  function automatic bit link_new(logic [63:0] k, logic [63:0] v, int b);
    int s;
    s = sh_count;
    if (s >= ENTRIES) return 1'b0;
    sh_key[s] = k;
    sh_val[s] = v;
    sh_bkt[s] = b;
    sh_next[s] = sh_head[b];
    sh_prev[s] = NIL;
    if (sh_head[b] < ENTRIES) sh_prev[sh_head[b]] = s;
    sh_head[b] = s;
    sh_count = s + 1;
    return 1'b1;
  endfunction

  // Unlink a slot, then move the last slot into the hole.
  function automatic void unlink_slot(int i, int b);
    int p, n, last, lp, ln, lb;
    p = sh_prev[i];
    n = sh_next[i];
    if (p < ENTRIES) sh_next[p] = n;
    else sh_head[b] = n;
    if (n < ENTRIES) sh_prev[n] = p;
    last = sh_count - 1;
    if (i != last) begin
      lp = sh_prev[last];
      ln = sh_next[last];
      lb = sh_bkt[last];
      sh_key[i] = sh_key[last];
      sh_val[i] = sh_val[last];
      sh_bkt[i] = lb;
      sh_prev[i] = lp;
      sh_next[i] = ln;
      if (lp < ENTRIES) sh_next[lp] = i;
      else sh_head[lb] = i;
      if (ln < ENTRIES) sh_prev[ln] = i;
    end
    sh_count = last;
  endfunction

  function automatic rsp_t predict_table_op(req_t r);
    rsp_t o;
    int b, i;
    o = '0;
    o.status = ST_OK;
    b = r.key_hash % ENTRIES;
    case (r.op)
      OP_GET: begin
        i = find_slot(r.key, b);
        if (i == NIL) o.status = ST_NOT_FOUND;
        else o.value_out = sh_val[i];
      end
      OP_INSERT: begin
        if (find_slot(r.key, b) != NIL) o.status = ST_PRESENT;
        else if (!link_new(r.key, r.value, b)) o.status = ST_FULL;
      end
      OP_SET: begin
        i = find_slot(r.key, b);
        if (i == NIL) o.status = ST_NOT_FOUND;
        else sh_val[i] = r.value;
      end
      OP_SET_INSERT: begin
        i = find_slot(r.key, b);
        if (i != NIL) sh_val[i] = r.value;
        else if (!link_new(r.key, r.value, b)) o.status = ST_FULL;
      end
      OP_ERASE: begin
        i = find_slot(r.key, b);
        if (i == NIL) o.status = ST_NOT_FOUND;
        else unlink_slot(i, b);
      end
      OP_READ_INDEX: begin
        if (r.slot_index >= sh_count) o.status = ST_RANGE;
        else begin
          o.key_out = sh_key[r.slot_index];
          o.value_out = sh_val[r.slot_index];
        end
      end
      OP_CLEAR: begin
        for (int j = 0; j < ENTRIES; j++) sh_head[j] = NIL;
        sh_count = 0;
      end
      default: ;
    endcase
    o.entry_count = sh_count[10:0];
    return o;
  endfunction

  // Driver: presents queued requests, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) expected_rsps.push_back(predict_table_op(req));
      if (pending_reqs.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each response transaction against the oldest prediction.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected response %h", $realtime, rsp);
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status)
            $display("%0t status exp %0d got %0d", $realtime, e.status, rsp.status);
          if (rsp.key_out !== e.key_out)
            $display("%0t key_out exp %h got %h", $realtime, e.key_out, rsp.key_out);
          if (rsp.value_out !== e.value_out)
            $display("%0t value_out exp %h got %h", $realtime, e.value_out, rsp.value_out);
          if (rsp.entry_count !== e.entry_count)
            $display("%0t entry_count exp %0d got %0d", $realtime, e.entry_count,
                     rsp.entry_count);
          if (rsp !== e) fail_count++;
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic req_t make_req(logic [2:0] op, logic [63:0] k, logic [31:0] h,
                                    logic [63:0] v, logic [9:0] s);
    req_t r;
    r.op = op;
    r.key = k;
    r.key_hash = h;
    r.value = v;
    r.slot_index = s;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Keys drawn from a small pool so that hits, misses and collisions all occur.
  logic [63:0] key_pool [16];

  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_random(int n, int bucket_span);
    int p;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(15);
      op = $urandom_range(99) < 3 ? OP_CLEAR : 3'($urandom_range(5));
      if ($urandom_range(49) == 0) op = 3'd7;
      pending_reqs.push_back(make_req(op,
        ($urandom_range(9) == 0) ? rand64() : key_pool[p],
        {22'($urandom), 10'(p % bucket_span)},
        rand64(), 10'($urandom_range(20))));
    end
  endtask

  initial begin
    for (int j = 0; j < ENTRIES; j++) sh_head[j] = NIL;
    sh_count = 0;
    for (int j = 0; j < 16; j++) key_pool[j] = rand64();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation and the special cases.
    pending_reqs.push_back(make_req(OP_GET, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_READ_INDEX, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_INSERT, '0, '0, '1, '0));
    pending_reqs.push_back(make_req(OP_INSERT, '1, '1, '0, '1));
    pending_reqs.push_back(make_req(OP_INSERT, 64'd5, 32'h400, 64'h55, '0));
    pending_reqs.push_back(make_req(OP_INSERT, 64'd5, 32'h400, 64'h66, '0));
    pending_reqs.push_back(make_req(OP_SET, 64'd5, 32'h400, 64'h77, '0));
    pending_reqs.push_back(make_req(OP_SET, 64'd9, 32'h400, 64'h77, '0));
    pending_reqs.push_back(make_req(OP_SET_INSERT, 64'd9, 32'h800, 64'h99, '0));
    pending_reqs.push_back(make_req(OP_SET_INSERT, 64'd9, 32'h800, '1, '0));
    pending_reqs.push_back(make_req(OP_GET, 64'd9, 32'h800, '0, '0));
    pending_reqs.push_back(make_req(OP_READ_INDEX, '0, '0, '0, 10'd4));
    pending_reqs.push_back(make_req(OP_READ_INDEX, '0, '0, '0, 10'd1023));
    pending_reqs.push_back(make_req(OP_ERASE, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_ERASE, 64'd77, 32'h0, '0, '0));
    pending_reqs.push_back(make_req(OP_READ_INDEX, '0, '0, '0, 10'd0));
    pending_reqs.push_back(make_req(3'd7, '1, '1, '1, '1));
    pending_reqs.push_back(make_req(OP_CLEAR, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_GET, 64'd5, 32'h400, '0, '0));
    add_random(150, 4);
    drain();

    // The sender is held off once every response is back.
    hold_sender = 1'b1;
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;

    // Load a few hundred entries onto eight long chains.
    send_idle_pct = 85;
    recv_idle_pct = 17;
    for (int j = 0; j < 300; j++)
      pending_reqs.push_back(make_req(($urandom_range(1) != 0) ? OP_INSERT : OP_SET_INSERT,
        {32'($urandom), 32'(j)}, {22'($urandom), 10'(j % 8)}, rand64(), '0));
    pending_reqs.push_back(make_req(OP_READ_INDEX, '0, '0, '0, 10'd1023));
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(60, 1024);
    pending_reqs.push_back(make_req(OP_CLEAR, '0, '0, '0, '0));
    add_random(170, 3);
    drain();
    repeat (ENTRIES + 20) @(posedge clk);

    if (fail_count == 0 && expected_rsps.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
design/chme_pkg.sv
design/chained_hash_map_engine.sv
bench/testbench.sv
